// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned TAG_W       = 64;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned OUTCOME_W   = 2;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 104;

  // configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned SET_BITS_W  = 3;
  localparam int unsigned BLK_BITS_W  = 6;
  localparam int unsigned WAYS_CFG_W  = 3;

  // effective set bits and shift amount, wide enough for the largest set count
  localparam int unsigned SB_W        = 4;
  localparam int unsigned SHIFT_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FETCH  = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_STORE  = 2'd2,
    FUNC_MODIFY = 2'd3
  } func_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_HIT   = 2'd0,
    OC_FILL  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_e;

endpackage

// ===== rtl/sacl_front.sv =====
module sacl_front #(
  parameter int unsigned SIW  = 4,
  parameter int unsigned OP_W = 69
) (
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  input  logic [sacl_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  logic [sacl_pkg::SB_W-1:0]          set_bits_eff_i,
  input  logic [sacl_pkg::BLK_BITS_W-1:0]    block_bits_i,
  output logic                               push_valid_o,
  input  logic                               push_ready_i,
  output logic [OP_W-1:0]                    push_op_o
);
  import sacl_pkg::*;

  func_e                 func;
  logic [ADDR_W-1:0]     addr;
  logic [ADDR_W-1:0]     above;
  logic [SHIFT_W-1:0]    shift;
  logic [TAG_W-1:0]      tag;
  logic [SIW-1:0]        set_mask;
  logic [SIW-1:0]        set_idx;

  // unpack the transfer
  assign func = func_e'(s_tdata_i[FUNC_W-1:0]);
  assign addr = s_tdata_i[FUNC_W +: ADDR_W];

  // address split into offset, set index and tag
  assign above = addr >> block_bits_i;
  assign shift = SHIFT_W'(set_bits_eff_i) + SHIFT_W'(block_bits_i);
  assign tag   = (shift >= SHIFT_W'(ADDR_W)) ? '0 : (addr >> shift[5:0]);

  always_comb begin
    for (int j = 0; j < SIW; j++) begin
      set_mask[j] = (SB_W'(j) < set_bits_eff_i);
    end
  end

  assign set_idx = above[SIW-1:0] & set_mask;

  // fetches are taken and dropped, everything else goes to the queue
  assign s_tready_o   = push_ready_i;
  assign push_valid_o = s_tvalid_i && (func != FUNC_FETCH);
  assign push_op_o    = {func == FUNC_MODIFY, set_idx, tag};

endmodule

// ===== rtl/sacl_queue.sv =====
module sacl_queue #(
  parameter int unsigned WIDTH = 69
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'(DEPTH));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/sacl_back.sv =====
module sacl_back #(
  parameter int unsigned MAX_SET_BITS = 4,
  parameter int unsigned MAX_WAYS     = 4,
  parameter int unsigned SIW          = 4,
  parameter int unsigned OP_W         = 69
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sacl_pkg::WAYS_CFG_W-1:0]    ways_in_use_i,
  input  logic                               op_valid_i,
  output logic                               op_ready_o,
  input  logic [OP_W-1:0]                    op_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [sacl_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  output logic                               m_tlast_o
);
  import sacl_pkg::*;

  localparam int unsigned NSETS = 1 << MAX_SET_BITS;
  localparam int unsigned WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WP    = 1 << WW;
  localparam int unsigned WCW   = $clog2(MAX_WAYS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_SECOND = 3'b100
  } state_e;

  state_e state_q, state_d;

  // set rows: tags and stamps in memory, valid bits in flops
  logic [TAG_W-1:0]    tag_mem   [NSETS][MAX_WAYS];
  logic [STAMP_W-1:0]  stamp_mem [NSETS][MAX_WAYS];
  logic [MAX_WAYS-1:0] valid_q   [NSETS];
  logic [TAG_W-1:0]    tag_rd_q   [MAX_WAYS];
  logic [STAMP_W-1:0]  stamp_rd_q [MAX_WAYS];

  // access being worked on
  logic [TAG_W-1:0]    cur_tag_q;
  logic [SIW-1:0]      cur_set_q;
  logic                cur_mod_q;
  logic [WW-1:0]       way_q, way_d;

  // counters
  logic [STAMP_W-1:0]  stamp_cnt_q, stamp_cnt_d;
  logic [CNT_W-1:0]    hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]    miss_cnt_q, miss_cnt_d;
  logic [CNT_W-1:0]    evict_cnt_q, evict_cnt_d;

  // result register
  logic                m_valid_q;
  logic [OUTCOME_W-1:0] outcome_q, outcome_d;
  logic                last_q, last_d;
  logic                out_free, out_load;

  // lookup
  logic [WCW-1:0]      ways_eff;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] valid_row;
  logic [MAX_WAYS-1:0] hit_vec, empty_vec;
  logic [WW-1:0]       hit_way, empty_way, victim;
  logic [STAMP_W-1:0]  nst  [WP];
  logic                nact [WP];
  logic [WW-1:0]       nidx [WP];

  // memory port control
  logic                rd_en;
  logic                wr_en, wr_tag_en, fill;
  logic [WW-1:0]       wr_way;
  logic [SIW-1:0]      op_set;

  assign op_set   = op_i[TAG_W +: SIW];
  assign out_free = !m_valid_q || m_tready_i;

  // effective associativity
  always_comb begin
    if (ways_in_use_i == '0) begin
      ways_eff = WCW'(1);
    end else if (32'(ways_in_use_i) > 32'(MAX_WAYS)) begin
      ways_eff = WCW'(MAX_WAYS);
    end else begin
      ways_eff = WCW'(ways_in_use_i);
    end
  end

  assign valid_row = valid_q[cur_set_q];

  // per-way hit and empty flags with lowest-way priority
  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]    = (WCW'(w) < ways_eff);
      hit_vec[w]   = in_use[w] && valid_row[w] && (tag_rd_q[w] == cur_tag_q);
      empty_vec[w] = in_use[w] && !valid_row[w];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WW'(w);
      end
      if (empty_vec[w]) begin
        empty_way = WW'(w);
      end
    end
  end

  // oldest-stamp tree, ties keep the lower way
  always_comb begin
    for (int i = 0; i < WP; i++) begin
      nst[i]  = '1;
      nact[i] = 1'b0;
      nidx[i] = WW'(i);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      nst[i]  = stamp_rd_q[i];
      nact[i] = in_use[i];
    end
    for (int s = 1; s < WP; s = s * 2) begin
      for (int i = 0; i < WP; i = i + 2 * s) begin
        if (nact[i + s] && (!nact[i] || (nst[i + s] < nst[i]))) begin
          nst[i]  = nst[i + s];
          nact[i] = 1'b1;
          nidx[i] = nidx[i + s];
        end
      end
    end
    victim = nidx[0];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_tag_en   = 1'b0;
    fill        = 1'b0;
    wr_way      = way_q;
    way_d       = way_q;
    out_load    = 1'b0;
    outcome_d   = outcome_q;
    last_d      = last_q;
    stamp_cnt_d = stamp_cnt_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          rd_en   = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          wr_en       = 1'b1;
          out_load    = 1'b1;
          last_d      = !cur_mod_q;
          stamp_cnt_d = stamp_cnt_q + STAMP_W'(1);
          if (|hit_vec) begin
            wr_way    = hit_way;
            outcome_d = OC_HIT;
            hit_cnt_d = hit_cnt_q + CNT_W'(1);
          end else if (|empty_vec) begin
            wr_way     = empty_way;
            wr_tag_en  = 1'b1;
            fill       = 1'b1;
            outcome_d  = OC_FILL;
            miss_cnt_d = miss_cnt_q + CNT_W'(1);
          end else begin
            wr_way      = victim;
            wr_tag_en   = 1'b1;
            outcome_d   = OC_EVICT;
            miss_cnt_d  = miss_cnt_q + CNT_W'(1);
            evict_cnt_d = evict_cnt_q + CNT_W'(1);
          end
          way_d   = wr_way;
          state_d = cur_mod_q ? ST_SECOND : ST_IDLE;
        end
      end
      ST_SECOND: begin
        // second half of a modify always hits the line just touched
        if (out_free) begin
          wr_en       = 1'b1;
          out_load    = 1'b1;
          last_d      = 1'b1;
          outcome_d   = OC_HIT;
          stamp_cnt_d = stamp_cnt_q + STAMP_W'(1);
          hit_cnt_d   = hit_cnt_q + CNT_W'(1);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign op_ready_o = (state_q == ST_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_valid_q   <= 1'b0;
      stamp_cnt_q <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      for (int s = 0; s < NSETS; s++) begin
        valid_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      stamp_cnt_q <= stamp_cnt_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (fill) begin
        valid_q[cur_set_q][wr_way] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    way_q     <= way_d;
    outcome_q <= outcome_d;
    last_q    <= last_d;
    if (rd_en) begin
      cur_tag_q <= op_i[TAG_W-1:0];
      cur_set_q <= op_set;
      cur_mod_q <= op_i[OP_W-1];
    end
  end

  // set row memory, one row read or written per cycle
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (rd_en) begin
        tag_rd_q[w]   <= tag_mem[op_set][w];
        stamp_rd_q[w] <= stamp_mem[op_set][w];
      end
      if (wr_en && (wr_way == WW'(w))) begin
        stamp_mem[cur_set_q][w] <= stamp_cnt_q;
        if (wr_tag_en) begin
          tag_mem[cur_set_q][w] <= cur_tag_q;
        end
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tlast_o  = last_q;
  assign m_tdata_o  = {6'd0, evict_cnt_q, miss_cnt_q, hit_cnt_q, outcome_q};

  // every result moves the hit plus miss total by exactly one
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((hit_cnt_q + miss_cnt_q) ==
                  ($past(hit_cnt_q) + $past(miss_cnt_q) + 32'd1)))
    else $error("hit plus miss total did not advance by one");

  // eviction only when no way in use is empty
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (outcome_d == OC_EVICT)) |-> (empty_vec == '0))
    else $error("eviction while an empty way exists");

  // a fill never overwrites a valid line
  a_fill_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill |-> !valid_row[wr_way])
    else $error("fill into a valid way");

  // second half of a modify is a hit and closes the run
  a_second_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SECOND) && out_free) |=>
      (m_valid_q && (outcome_q == OC_HIT) && last_q))
    else $error("second access of a modify is not a final hit");

  // a hit and an empty way in use cannot refer to the same way
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EVAL) && (|hit_vec)) |-> ((hit_vec & empty_vec) == '0))
    else $error("hit on an invalid way");

endmodule

// ===== rtl/set_assoc_cache_lru_sim.sv =====
// Set-associative cache model with true LRU replacement. Each trace transfer
// (func, address) is taken by the front end, which drops instruction fetches,
// splits the address into set index and tag under the current configuration
// and places the access in a two-entry queue. The back end runs one access
// at a time against a per-set row memory: a read step fetches the row (tags
// and stamps, registered read data), then a compare step chooses the way
// and writes back. A modify then makes a second access, always a hit, that
// restamps the same way without a read.
// Results leave through an output register; while one result waits the back
// end can still read the next row, but holds in its compare step until the
// register is free. Valid bits sit in flops cleared at reset, so no
// clearing pass is needed. Configuration writes do not flush the cache.
// Running hit, miss and eviction totals wrap at 32 bits.
module set_assoc_cache_lru_sim #(
  parameter int unsigned MAX_SET_BITS = 4,
  parameter int unsigned MAX_WAYS     = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // access stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] func, [65:2] access_address, [71:66] zero
  input  logic [sacl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] outcome, [33:2] hits_total, [65:34] misses_total,
  // [97:66] evictions_total, [103:98] zero
  output logic [sacl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import sacl_pkg::*;

  localparam int unsigned SIW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned OP_W = 1 + SIW + TAG_W;

  logic [SET_BITS_W-1:0] set_bits_q;
  logic [BLK_BITS_W-1:0] block_bits_q;
  logic [WAYS_CFG_W-1:0] ways_q;
  logic [SB_W-1:0]       set_bits_eff;

  logic                  push_valid, push_ready;
  logic [OP_W-1:0]       push_op;
  logic                  pop_valid, pop_ready;
  logic [OP_W-1:0]       pop_op;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= BLK_BITS_W'(4);
      ways_q       <= WAYS_CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[BLK_BITS_W-1:0];
        CFG_WAYS:       ways_q       <= cfg_data_i[WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // set bits beyond the built set count are clamped
  assign set_bits_eff = (SB_W'(set_bits_q) > SB_W'(MAX_SET_BITS)) ?
                        SB_W'(MAX_SET_BITS) : SB_W'(set_bits_q);

  sacl_front #(
    .SIW  (SIW),
    .OP_W (OP_W)
  ) u_front (
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_o     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .set_bits_eff_i (set_bits_eff),
    .block_bits_i   (block_bits_q),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_op_o      (push_op)
  );

  sacl_queue #(
    .WIDTH (OP_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_op)
  );

  sacl_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .SIW          (SIW),
    .OP_W         (OP_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ways_in_use_i (ways_q),
    .op_valid_i    (pop_valid),
    .op_ready_o    (pop_ready),
    .op_i          (pop_op),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_o     (m_axis_tdata),
    .m_tlast_o     (m_axis_tlast)
  );

endmodule
